### hw/rtl/npcs_pkg.sv
// ----------------------------------------------------------------------------
// npcs_pkg: nearest palette color search package
// Shared widths, limits and the item types that move along the cell chain.
// ----------------------------------------------------------------------------
package npcs_pkg;

  localparam int unsigned ColorW      = 8;   // one color component
  localparam int unsigned SqW         = 16;  // square of a component difference
  localparam int unsigned DistW       = 18;  // sum of three squares, max 195075
  localparam int unsigned IdxFieldW   = 7;   // entry_index / nearest_index ports
  localparam int unsigned EntryW      = 8;   // index carried in the chain
  localparam int unsigned CbW         = 3;   // color_bits register
  localparam int unsigned MinColorBits = 3;

  // Commands
  localparam logic CmdLoad  = 1'b0;
  localparam logic CmdQuery = 1'b1;

  // One transfer as it moves through the chain (valid travels separately)
  typedef struct packed {
    logic              cmd;
    logic [EntryW-1:0] entry;
    logic [ColorW-1:0] red;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] blue;
  } item_t;

  // Running best match of a query
  typedef struct packed {
    logic [EntryW-1:0] idx;
    logic [DistW-1:0]  distance;
  } best_t;

  function automatic logic [SqW-1:0] sq_diff(input logic [ColorW-1:0] a,
                                             input logic [ColorW-1:0] b);
    logic [ColorW-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return SqW'(d) * SqW'(d);
  endfunction

endpackage

### hw/rtl/npcs_cell.sv
// ----------------------------------------------------------------------------
// npcs_cell: one palette entry cell
// Holds one entry. Stage A squares the component differences, stage B sums
// them and updates the running best match of a passing query.
// ----------------------------------------------------------------------------
module npcs_cell #(
  parameter int unsigned IdxW    = 7,
  parameter int unsigned CellIdx = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,    // whole chain moves
  input  logic                  en_i,     // entry inside searched range
  input  logic                  vld_i,
  input  npcs_pkg::item_t       item_i,
  input  npcs_pkg::best_t       best_i,
  output logic                  vld_o,
  output npcs_pkg::item_t       item_o,
  output npcs_pkg::best_t       best_o
);

  logic [3*npcs_pkg::ColorW-1:0] entry_q;

  logic                         a_vld_q;
  npcs_pkg::item_t              a_item_q;
  npcs_pkg::best_t              a_best_q;
  logic [npcs_pkg::SqW-1:0]     sq_r_q, sq_g_q, sq_b_q;

  logic                         b_vld_q;
  npcs_pkg::item_t              b_item_q;
  npcs_pkg::best_t              b_best_q, b_best_d;
  logic [npcs_pkg::DistW-1:0]   dist_sum;

  logic wr_hit;
  assign wr_hit = vld_i && (item_i.cmd == npcs_pkg::CmdLoad) &&
                  (item_i.entry[IdxW-1:0] == IdxW'(CellIdx));

  // Entry store, undefined until written
  always_ff @(posedge clk_i) begin
    if (adv_i && wr_hit) begin
      entry_q <= {item_i.red, item_i.green, item_i.blue};
    end
  end

  // Stage A: squares
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (adv_i) begin
      a_vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a_item_q <= item_i;
      a_best_q <= best_i;
      sq_r_q   <= npcs_pkg::sq_diff(entry_q[23:16], item_i.red);
      sq_g_q   <= npcs_pkg::sq_diff(entry_q[15:8],  item_i.green);
      sq_b_q   <= npcs_pkg::sq_diff(entry_q[7:0],   item_i.blue);
    end
  end

  // Stage B: sum and compare; the first cell always takes the lead
  assign dist_sum = npcs_pkg::DistW'(sq_r_q) + npcs_pkg::DistW'(sq_g_q) +
                    npcs_pkg::DistW'(sq_b_q);

  always_comb begin
    b_best_d = a_best_q;
    if (a_item_q.cmd == npcs_pkg::CmdQuery && en_i) begin
      if (CellIdx == 0 || dist_sum < a_best_q.distance) begin
        b_best_d.idx      = npcs_pkg::EntryW'(CellIdx);
        b_best_d.distance = dist_sum;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (adv_i) begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      b_item_q <= a_item_q;
      b_best_q <= b_best_d;
    end
  end

  assign vld_o  = b_vld_q;
  assign item_o = b_item_q;
  assign best_o = b_best_q;

endmodule

### hw/rtl/nearest_palette_color_search_top.sv
// A query passes stages A and B of every cell in turn, then the output register.
// Throughput: one item per cycle while the chain is not held; loads and queries flow through the cell chain in order.
// A query's result stalls the chain only when it reaches the tail while the output is held.
// Reset: rst_ni asynchronous, active low; clears valids and sets color_bits to MAX_COLOR_BITS, at most 7.
// Palette entries are not reset and hold garbage until loaded.
// ----------------------------------------------------------------------------
// nearest_palette_color_search_top: nearest palette color search
// A chain of entry cells, one per palette entry. Every transfer walks the
// chain two stages per cell; a load is captured by its cell, a query picks
// up the closest entry seen so far and leaves at the tail as a result.
// ----------------------------------------------------------------------------
module nearest_palette_color_search_top #(
  parameter int unsigned MAX_COLOR_BITS = 7
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [npcs_pkg::CbW-1:0]          cfg_wdata_i,
  // input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              command_i,
  input  logic [npcs_pkg::IdxFieldW-1:0]    entry_index_i,
  input  logic [npcs_pkg::ColorW-1:0]       red_i,
  input  logic [npcs_pkg::ColorW-1:0]       green_i,
  input  logic [npcs_pkg::ColorW-1:0]       blue_i,
  // output channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [npcs_pkg::IdxFieldW-1:0]    nearest_index_o,
  output logic [npcs_pkg::DistW-1:0]        nearest_distance_o
);

  localparam int unsigned NumCells = 1 << MAX_COLOR_BITS;
  localparam int unsigned LimW     = MAX_COLOR_BITS + 1;
  localparam int unsigned ResetCb  = (MAX_COLOR_BITS < 7) ? MAX_COLOR_BITS : 7;

  // color_bits register, saturated to MinColorBits..MAX_COLOR_BITS
  logic [npcs_pkg::CbW-1:0] cb_q, cb_d;

  always_comb begin
    cb_d = cfg_wdata_i;
    if (int'(cfg_wdata_i) < npcs_pkg::MinColorBits) begin
      cb_d = npcs_pkg::CbW'(npcs_pkg::MinColorBits);
    end else if (int'(cfg_wdata_i) > MAX_COLOR_BITS) begin
      cb_d = npcs_pkg::CbW'(MAX_COLOR_BITS);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cb_q <= npcs_pkg::CbW'(ResetCb);
    end else if (cfg_we_i) begin
      cb_q <= cb_d;
    end
  end

  // number of searched entries
  logic [LimW-1:0] cb_limit;
  assign cb_limit = LimW'(1) << cb_q;

  // chain wiring, element 0 is the input, element NumCells the tail
  logic            chain_vld  [NumCells+1];
  npcs_pkg::item_t chain_item [NumCells+1];
  npcs_pkg::best_t chain_best [NumCells+1];
  logic [NumCells-1:0] cell_en;
  logic adv, hold, tail_query;

  assign chain_vld[0]        = in_valid_i;
  assign chain_item[0].cmd   = command_i;
  assign chain_item[0].entry = npcs_pkg::EntryW'(entry_index_i);
  assign chain_item[0].red   = red_i;
  assign chain_item[0].green = green_i;
  assign chain_item[0].blue  = blue_i;
  assign chain_best[0]       = '0;

  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    assign cell_en[g] = (LimW'(g) < cb_limit);

    npcs_cell #(
      .IdxW    (MAX_COLOR_BITS),
      .CellIdx (g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .en_i   (cell_en[g]),
      .vld_i  (chain_vld[g]),
      .item_i (chain_item[g]),
      .best_i (chain_best[g]),
      .vld_o  (chain_vld[g+1]),
      .item_o (chain_item[g+1]),
      .best_o (chain_best[g+1])
    );
  end

  // The chain halts only when a query result sits at the tail and the
  // output register is still waiting for its transfer. Loads and bubbles
  // at the tail leave freely.
  assign tail_query = chain_vld[NumCells] &&
                      (chain_item[NumCells].cmd == npcs_pkg::CmdQuery);
  assign hold       = out_valid_o && out_stall_i && tail_query;
  assign adv        = !hold;
  assign in_stall_o = hold;

  // output register
  logic                      out_vld_q;
  logic [npcs_pkg::EntryW-1:0] out_idx_q;
  logic [npcs_pkg::DistW-1:0]  out_dist_q;
  logic out_load;

  assign out_load = !(out_vld_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= tail_query;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && tail_query) begin
      out_idx_q  <= chain_best[NumCells].idx;
      out_dist_q <= chain_best[NumCells].distance;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign nearest_index_o    = out_idx_q[npcs_pkg::IdxFieldW-1:0];
  assign nearest_distance_o = out_dist_q;

`ifndef NO_ASSERTIONS
  // a held tail query keeps the result pending
  a_hold_keeps_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold |=> out_valid_o)
    else $error("result dropped while chain held");

  // a new result only comes from a query at the tail
  a_out_from_query : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(tail_query))
    else $error("result without query");

  // the reported entry lies in the searched range
  a_idx_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (LimW'(out_idx_q) < cb_limit))
    else $error("nearest index outside searched range");

  // color_bits stays saturated
  a_cb_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (int'(cb_q) >= npcs_pkg::MinColorBits) && (int'(cb_q) <= MAX_COLOR_BITS))
    else $error("color_bits out of range");
`endif

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: nearest palette color search testbench
// Loads palette entries and sends pixel queries through the valid/stall
// input channel, predicts each query's closest entry and distance from a
// shadow copy of the palette, and checks every result transfer in order.
// Runs through several color_bits settings and idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_top;

  // ChainLatency and DrainCycles are sized for the block at MAX_COLOR_BITS = 7.
  localparam int ChainLatency = 2 * (1 << 7) + 1;
  localparam int DrainCycles  = ChainLatency + 40;
  localparam int LimitCycles  = 400000;
  localparam int RxHoldCycles = 800;
  localparam int NumPhases    = 8;

  typedef struct packed {
    logic       cmd;
    logic [6:0] index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } feed_item_t;

  typedef struct packed {
    logic [6:0]  idx;
    logic [17:0] distance;
  } match_t;

  // color_bits per phase: every value once, so every wdata bit toggles and
  // the saturating values (0, 1, 2 -> 3) get written.
  localparam logic [2:0] CfgSeq [NumPhases] = '{3'd7, 3'd0, 3'd5, 3'd2,
                                                3'd6, 3'd3, 3'd1, 3'd4};

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [2:0]  cfg_wdata_i   = '0;
  logic        in_valid_i    = 1'b0;
  logic        in_stall_o;
  logic        command_i     = 1'b0;
  logic [6:0]  entry_index_i = '0;
  logic [7:0]  red_i         = '0;
  logic [7:0]  green_i       = '0;
  logic [7:0]  blue_i        = '0;
  logic        out_valid_o;
  logic        out_stall_i   = 1'b1;
  logic [6:0]  nearest_index_o;
  logic [17:0] nearest_distance_o;

  // Stimulus and prediction state
  feed_item_t item_feed[$];        // items waiting for the driver
  match_t     expected_matches[$]; // predicted results, oldest first
  logic [23:0] shadow_palette [128];
  int         color_bits_model = 7;
  int         send_idle_pct    = 0;
  int         recv_stall_pct   = 0;
  int         error_count      = 0;
  int         cycle_count      = 0;

  // Handshake bookkeeping between driver and monitor
  int         offers_made  = 0;
  int         transfers_in = 0;
  bit         offering     = 1'b0;
  feed_item_t on_offer     = '0;

  // Long receiver hold-off
  bit         hold_armed   = 1'b0;
  bit         hold_started = 1'b0;
  int         hold_left    = 0;

  nearest_palette_color_search_top #(
    .MAX_COLOR_BITS(7)
  ) u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .command_i         (command_i),
    .entry_index_i     (entry_index_i),
    .red_i             (red_i),
    .green_i           (green_i),
    .blue_i            (blue_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .nearest_index_o   (nearest_index_o),
    .nearest_distance_o(nearest_distance_o)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Squared-distance search over the first 2^color_bits entries;
  // strict less-than keeps the lowest index on ties.
  function automatic match_t nearest_entry_search(input logic [7:0] r,
                                                  input logic [7:0] g,
                                                  input logic [7:0] b);
    match_t m;
    int     best;
    int     d;
    int     dr;
    int     dg;
    int     db;
    m    = '0;
    best = 1 << 30;
    for (int i = 0; i < (1 << color_bits_model); i++) begin
      dr = int'(shadow_palette[i][23:16]) - int'(r);
      dg = int'(shadow_palette[i][15:8]) - int'(g);
      db = int'(shadow_palette[i][7:0]) - int'(b);
      d  = dr * dr + dg * dg + db * db;
      if (d < best) begin
        best = d;
        m.idx = 7'(i);
      end
    end
    m.distance = 18'(best);
    return m;
  endfunction

  // Component with extra weight on the extremes
  function automatic logic [7:0] rand_component();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return 8'd0;
    if (pick == 1) return 8'd255;
    return 8'($urandom_range(255));
  endfunction

  // Small offset around a palette color, clamped to 0..255
  function automatic logic [7:0] jitter(input logic [7:0] c);
    int v;
    v = int'(c) + int'($urandom_range(16)) - 8;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  task automatic push_item(input logic cmd, input logic [6:0] idx,
                           input logic [7:0] r, input logic [7:0] g,
                           input logic [7:0] b);
    feed_item_t it;
    it.cmd   = cmd;
    it.index = idx;
    it.red   = r;
    it.green = g;
    it.blue  = b;
    item_feed.push_back(it);
  endtask

  // Random mix: 30 percent loads (mostly inside the searched span), the rest
  // queries, half of them close to a stored color.
  task automatic queue_random_items(input int n);
    int         span;
    int         pick;
    logic [6:0] idx;
    logic [23:0] c;
    span = 1 << color_bits_model;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        if ($urandom_range(1) == 1) idx = 7'($urandom_range(span - 1));
        else idx = 7'($urandom_range(127));
        push_item(npcs_pkg::CmdLoad, idx, rand_component(), rand_component(),
                  rand_component());
      end else if (pick < 65) begin
        c = shadow_palette[$urandom_range(span - 1)];
        push_item(npcs_pkg::CmdQuery, 7'($urandom_range(127)), jitter(c[23:16]),
                  jitter(c[15:8]), jitter(c[7:0]));
      end else begin
        push_item(npcs_pkg::CmdQuery, 7'($urandom_range(127)), rand_component(),
                  rand_component(), rand_component());
      end
    end
  endtask

  // Wait until the block holds nothing: all items taken, all results back,
  // then the DrainCycles wait so trailing loads have landed.
  task automatic settle_idle();
    while (item_feed.size() != 0 || offering) @(negedge clk_i);
    while (expected_matches.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Register write; values below 3 saturate to 3.
  task automatic write_color_bits(input logic [2:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    color_bits_model = (val < npcs_pkg::MinColorBits) ? npcs_pkg::MinColorBits
                                                      : int'(val);
  endtask

  // Driver: presents the next item at the falling edge, holds it while
  // stalled, and drops valid on random idle cycles between transfers.
  always @(negedge clk_i) begin
    if (offering && transfers_in == offers_made) begin
      offering = 1'b0;
    end
    if (rst_ni && !offering && item_feed.size() != 0 &&
        $urandom_range(99) >= send_idle_pct) begin
      on_offer = item_feed.pop_front();
      offering = 1'b1;
      offers_made++;
    end
    in_valid_i    <= offering;
    command_i     <= on_offer.cmd;
    entry_index_i <= on_offer.index;
    red_i         <= on_offer.red;
    green_i       <= on_offer.green;
    blue_i        <= on_offer.blue;
    out_stall_i   <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
  end

  // Receiver hold-off counter, runs once when armed
  always @(posedge clk_i) begin
    if (hold_armed && !hold_started) begin
      hold_started = 1'b1;
      hold_left    = RxHoldCycles;
    end else if (hold_left != 0) begin
      hold_left--;
    end
  end

  // Monitor: input transfers update the shadow palette or queue a
  // prediction; output transfers are checked against the oldest one.
  always @(posedge clk_i) begin
    match_t want;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      transfers_in++;
      if (command_i == npcs_pkg::CmdLoad) begin
        shadow_palette[entry_index_i] = {red_i, green_i, blue_i};
      end else begin
        expected_matches.push_back(nearest_entry_search(red_i, green_i, blue_i));
      end
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_matches.size() == 0) begin
        $error("result transfer with no query pending: index %0d distance %0d",
               nearest_index_o, nearest_distance_o);
        error_count++;
      end else begin
        want = expected_matches.pop_front();
        if (nearest_index_o !== want.idx) begin
          $error("nearest_index: expected %0d, got %0d", want.idx, nearest_index_o);
          error_count++;
        end
        if (nearest_distance_o !== want.distance) begin
          $error("nearest_distance: expected %0d, got %0d", want.distance,
                 nearest_distance_o);
          error_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LimitCycles) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    logic [23:0] tie_color;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int p = 0; p < NumPhases; p++) begin
      settle_idle();
      write_color_bits(CfgSeq[p]);
      // sender 36 / receiver 57, then swapped, then no idling
      if (p < 3) begin
        send_idle_pct  = 36;
        recv_stall_pct = 57;
      end else if (p < 6) begin
        send_idle_pct  = 57;
        recv_stall_pct = 36;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end

      if (p == 0) begin
        // Fill the whole palette before any query so nothing unwritten is
        // ever searched. Black at 0, white at 127, a duplicate pair 40/41.
        tie_color = {8'($urandom_range(255)), 8'($urandom_range(255)),
                     8'($urandom_range(255))};
        for (int i = 0; i < 128; i++) begin
          if (i == 0)
            push_item(npcs_pkg::CmdLoad, 7'(i), 8'd0, 8'd0, 8'd0);
          else if (i == 127)
            push_item(npcs_pkg::CmdLoad, 7'(i), 8'd255, 8'd255, 8'd255);
          else if (i == 40 || i == 41)
            push_item(npcs_pkg::CmdLoad, 7'(i), tie_color[23:16], tie_color[15:8],
                      tie_color[7:0]);
          else
            push_item(npcs_pkg::CmdLoad, 7'(i), 8'($urandom_range(1, 254)),
                      8'($urandom_range(1, 254)), 8'($urandom_range(1, 254)));
        end
        push_item(npcs_pkg::CmdQuery, 7'd0, 8'd0, 8'd0, 8'd0);
        push_item(npcs_pkg::CmdQuery, 7'd127, 8'd255, 8'd255, 8'd255);
        push_item(npcs_pkg::CmdQuery, 7'd85, tie_color[23:16], tie_color[15:8],
                  tie_color[7:0]);
        push_item(npcs_pkg::CmdQuery, 7'd42, 8'd128, 8'd128, 8'd128);
        push_item(npcs_pkg::CmdQuery, 7'd0, 8'd255, 8'd0, 8'd255);
      end else if (p == 1) begin
        // Saturated to 3 bits: eight black entries, all tied at the
        // largest possible distance from white.
        for (int i = 0; i < 8; i++) begin
          push_item(npcs_pkg::CmdLoad, 7'(i), 8'd0, 8'd0, 8'd0);
        end
        push_item(npcs_pkg::CmdQuery, 7'd127, 8'd255, 8'd255, 8'd255);
        push_item(npcs_pkg::CmdQuery, 7'd0, 8'd0, 8'd255, 8'd0);
        // entries beyond the searched span must not win
        push_item(npcs_pkg::CmdLoad, 7'd8, 8'd255, 8'd255, 8'd255);
        push_item(npcs_pkg::CmdQuery, 7'd8, 8'd255, 8'd255, 8'd255);
      end

      if (p == NumPhases - 1) begin
        // Long receiver hold-off while the sender keeps offering: the chain
        // fills up and the input side must stall.
        hold_armed = 1'b1;
        queue_random_items(270);
      end else begin
        queue_random_items(8);
      end
    end

    settle_idle();
    if (error_count == 0 && expected_matches.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### nearest_palette_color_search_top.f
hw/rtl/npcs_pkg.sv
hw/rtl/npcs_cell.sv
hw/rtl/nearest_palette_color_search_top.sv
tb/sv/tb_top.sv
